// File: sv/swrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and microcode for the sliding window rate limiter
// Control word layout, step labels, the program ROM, register and verdict
// codes.
// ----------------------------------------------------------------------------
package swrl_pkg;

	localparam int unsigned LOG_DEPTH_DEF     = 8;
	localparam int unsigned WINDOW_LENGTH_DEF = 3600000;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned WAIT_W = 32;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned CFG_AW = 2;
	localparam int unsigned IN_W   = 56;
	localparam int unsigned OUT_W  = 40;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_COOLDOWN = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_HOURLY   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_BURST    = 2'd2;

	localparam logic [31:0] COOLDOWN_RST = 32'd60000;
	localparam logic [7:0]  HOURLY_RST   = 8'd5;
	localparam logic [7:0]  BURST_RST    = 8'd3;

	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_LIMIT    = 2'd1;
	localparam logic [1:0] VERDICT_COOLDOWN = 2'd2;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_RD,
		OP_SCAN_EV,
		OP_CALC,
		OP_DIFF,
		OP_RESULT,
		OP_SHIFT_INIT,
		OP_SHIFT_RD,
		OP_SHIFT_EV,
		OP_SHIFT_END,
		OP_APPEND
	} op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_ITEM,
		C_EMPTY,
		C_SCAN_MORE,
		C_OUT_BUSY,
		C_NO_REC,
		C_NOT_FULL,
		C_LAST_SLOT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// step labels
	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_SCAN_RD = 4'd1;
	localparam step_t S_SCAN_EV = 4'd2;
	localparam step_t S_CALC    = 4'd3;
	localparam step_t S_DIFF    = 4'd4;
	localparam step_t S_RESULT  = 4'd5;
	localparam step_t S_REC     = 4'd6;
	localparam step_t S_FULL    = 4'd7;
	localparam step_t S_SH_RD   = 4'd8;
	localparam step_t S_SH_EV   = 4'd9;
	localparam step_t S_SH_END  = 4'd10;
	localparam step_t S_APPEND  = 4'd11;

	localparam int unsigned NUM_STEPS = 12;

	// a taken condition jumps to target, otherwise the step counter advances
	localparam ctrl_word_t UCODE [NUM_STEPS] = '{
		'{OP_LOAD,       C_NO_ITEM,   S_IDLE},
		'{OP_SCAN_RD,    C_EMPTY,     S_CALC},
		'{OP_SCAN_EV,    C_SCAN_MORE, S_SCAN_RD},
		'{OP_CALC,       C_NONE,      S_IDLE},
		'{OP_DIFF,       C_NONE,      S_IDLE},
		'{OP_RESULT,     C_OUT_BUSY,  S_RESULT},
		'{OP_SHIFT_INIT, C_NO_REC,    S_IDLE},
		'{OP_NONE,       C_NOT_FULL,  S_APPEND},
		'{OP_SHIFT_RD,   C_LAST_SLOT, S_SH_END},
		'{OP_SHIFT_EV,   C_ALWAYS,    S_SH_RD},
		'{OP_SHIFT_END,  C_ALWAYS,    S_IDLE},
		'{OP_APPEND,     C_ALWAYS,    S_IDLE}
	};

endpackage
`default_nettype wire

// File: sv/sliding_window_rate_limiter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_unit: alert rate limiter over a time log
// Checks each request against a log of recent alert times (window limit and
// burst cooldown) and, on a record command, prunes and appends to the log.
// ----------------------------------------------------------------------------
//
//  group   | dir | payload (lowest bit first)
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | cmd[0], now_time[48:1], zero pad to 56 bits
//  m_*     | out | verdict[1:0], wait_time[33:2], wait_valid[34], active[35]
//  cfg_*   | in  | cfg_addr 0 cooldown_time, 1 hourly_limit, 2 burst_count
//
// A microcoded sequencer walks the log memory entry by entry (registered
// read, then evaluate). It loads the request, reads and evaluates every
// logged entry, then computes the limit, the difference and the result.
// After the result a check returns to idle; a record appends the new time,
// or, when the log stays full, shifts the oldest entry out and writes the
// new time last. Reset empties the log through its fill count; no clearing pass.
// A stalled result holds in the output register; the sequencer waits there.
module sliding_window_rate_limiter_unit #(
	parameter int unsigned LOG_DEPTH     = swrl_pkg::LOG_DEPTH_DEF,
	parameter int unsigned WINDOW_LENGTH = swrl_pkg::WINDOW_LENGTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [swrl_pkg::IN_W-1:0]   s_tdata,  // cmd, now_time
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [swrl_pkg::OUT_W-1:0]       m_tdata,  // verdict, wait_time, wait_valid, active
	input  wire logic                        cfg_we,
	input  wire logic [swrl_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [swrl_pkg::CFG_W-1:0]  cfg_data
);
	import swrl_pkg::*;

	localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
	localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(LOG_DEPTH - 1);
	localparam logic [TIME_W-1:0] WIN_C = TIME_W'(WINDOW_LENGTH);

	// configuration
	logic [31:0] cooldown_q;
	logic [7:0]  hourly_q;
	logic [7:0]  burst_q;

	// sequencer
	step_t      step_q;
	step_t      step_nxt;
	ctrl_word_t cw;
	logic       jump;

	// datapath
	logic              cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] cutoff_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     wr_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     win_q;
	logic [TIME_W-1:0] oldest_q;
	logic              found_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] rd_q;
	logic              lim_q;
	logic              bur_q;
	logic [49:0]       sum_q;
	logic signed [50:0] diff_q;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// log memory
	logic [TIME_W-1:0] log_mem [LOG_DEPTH];
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [TIME_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	logic [CW-1:0]     idx_inc;
	logic [TIME_W-1:0] in_now;
	logic              in_win;
	logic              out_busy;
	logic              res_fire;
	logic [7:0]        win8;
	logic [WAIT_W-1:0] sat_wait;
	logic              diff_pos;
	logic [1:0]        verdict;
	logic [WAIT_W-1:0] wait_time;
	logic              wait_valid;

	assign cw       = UCODE[step_q];
	assign idx_inc  = idx_q + CW'(1);
	assign in_now   = s_tdata[TIME_W:1];
	assign in_win   = (rd_q >= cutoff_q);
	assign out_busy = m_tvalid_q && !m_tready;
	assign res_fire = (cw.op == OP_RESULT) && !out_busy;
	assign win8     = 8'(win_q);

	assign s_tready = (step_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// jump condition
	always_comb begin
		unique case (cw.cond)
			C_NONE:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_ITEM:   jump = !s_tvalid;
			C_EMPTY:     jump = (count_q == '0);
			C_SCAN_MORE: jump = ({1'b0, idx_inc} < {1'b0, count_q});
			C_OUT_BUSY:  jump = out_busy;
			C_NO_REC:    jump = !cmd_q;
			C_NOT_FULL:  jump = (wr_q != DEPTH_C);
			C_LAST_SLOT: jump = (idx_q == LAST_C);
			default:     jump = 1'b0;
		endcase
		step_nxt = jump ? cw.target : step_q + 4'd1;
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_q[AW-1:0];
		mem_wd = rd_q;
		mem_re = 1'b0;
		mem_ra = idx_q[AW-1:0];
		unique case (cw.op)
			OP_SCAN_RD: begin
				mem_re = 1'b1;
			end
			OP_SCAN_EV: begin
				// compact in-window entries toward the head
				mem_we = cmd_q && in_win;
			end
			OP_SHIFT_RD: begin
				mem_re = (idx_q != LAST_C);
				mem_ra = idx_inc[AW-1:0];
			end
			OP_SHIFT_EV: begin
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
			end
			OP_SHIFT_END: begin
				mem_we = 1'b1;
				mem_wa = idx_q[AW-1:0];
				mem_wd = now_q;
			end
			OP_APPEND: begin
				mem_we = 1'b1;
				mem_wd = now_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			log_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= log_mem[mem_ra];
		end
	end

	// saturate the signed difference to the wait field
	always_comb begin
		diff_pos = !diff_q[50] && (diff_q != '0);
		if (!diff_pos) begin
			sat_wait = '0;
		end else if (|diff_q[49:WAIT_W]) begin
			sat_wait = '1;
		end else begin
			sat_wait = diff_q[WAIT_W-1:0];
		end
		verdict    = VERDICT_OK;
		wait_time  = '0;
		wait_valid = 1'b0;
		if (lim_q) begin
			verdict = VERDICT_LIMIT;
			if (found_q && (oldest_q != '0)) begin
				wait_time  = sat_wait;
				wait_valid = 1'b1;
			end
		end else if (bur_q && (last_q != '0) && diff_pos) begin
			verdict    = VERDICT_COOLDOWN;
			wait_time  = sat_wait;
			wait_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RST;
			hourly_q   <= HOURLY_RST;
			burst_q    <= BURST_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_COOLDOWN: cooldown_q <= cfg_data;
				CFG_HOURLY:   hourly_q   <= cfg_data[7:0];
				CFG_BURST:    burst_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (res_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cw.op == OP_APPEND) begin
				count_q <= wr_q + CW'(1);
			end else if (cw.op == OP_SHIFT_END) begin
				count_q <= DEPTH_C;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				cmd_q    <= s_tdata[0];
				now_q    <= in_now;
				cutoff_q <= (in_now >= WIN_C) ? in_now - WIN_C : '0;
				idx_q    <= '0;
				wr_q     <= '0;
				win_q    <= '0;
				found_q  <= 1'b0;
				oldest_q <= '0;
				last_q   <= '0;
			end
			OP_SCAN_EV: begin
				if (in_win) begin
					win_q <= win_q + CW'(1);
					if (!found_q || (rd_q < oldest_q)) begin
						oldest_q <= rd_q;
						found_q  <= 1'b1;
					end
					if (cmd_q) begin
						wr_q <= wr_q + CW'(1);
					end
				end
				last_q <= rd_q;
				idx_q  <= idx_inc;
			end
			OP_CALC: begin
				lim_q <= (win8 >= hourly_q);
				bur_q <= (win8 >= burst_q);
				if (win8 >= hourly_q) begin
					sum_q <= 50'(oldest_q) + 50'(WINDOW_LENGTH);
				end else begin
					sum_q <= 50'(last_q) + 50'(cooldown_q);
				end
			end
			OP_DIFF: begin
				diff_q <= $signed({1'b0, sum_q}) - $signed({3'b000, now_q});
			end
			OP_RESULT: begin
				if (!out_busy) begin
					m_tdata_q <= {4'b0000, (win_q != '0), wait_valid, wait_time, verdict};
				end
			end
			OP_SHIFT_INIT: begin
				idx_q <= '0;
			end
			OP_SHIFT_EV: begin
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
